// ----- src/key_value_table_assert.svh -----
// Assertion macros for the key-value table checker.
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH
// Checks a property outside reset.
`define KVT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks a property that also covers the reset cycles.
`define KVT_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/kvt_pkg.sv -----
// Shared types and constants for the key-value table.
`timescale 1ns / 1ps
package kvt_pkg;
  localparam int FUNC_BITS = 2;
  localparam int DATA_BITS = 64;

  localparam logic [FUNC_BITS-1:0] FUNC_GET = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_PUT = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_DEL = 2'd2;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan_step;
    logic act;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } status_t;
endpackage

// ----- src/key_value_table.sv -----
// Top level of the key-value table.
// Requests arrive on the in channel (func, lookup_key, store_value) and each
// one gives exactly one result on the out channel (success, read_value).
// A transaction completes on a rising edge where valid is high and stall low.
// Operations are get, put and delete; a put takes the lowest free entry when
// the key is absent and fails when the table is full.
// After reset a clearing pass marks every entry free, with in_stall high.
// A request walks the key memory one entry per cycle through its single read
// port, and one request is processed at a time: a new request is accepted
// only after the previous result has been loaded into the output register.
// The result sits in an output register: the next request is accepted and
// scanned while that result waits under out_stall, and only the result load
// waits for the register to free up.
`timescale 1ns / 1ps
module key_value_table #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kvt_pkg::FUNC_BITS-1:0] func,
  input  logic [kvt_pkg::DATA_BITS-1:0] lookup_key,
  input  logic [kvt_pkg::DATA_BITS-1:0] store_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          success,
  output logic [kvt_pkg::DATA_BITS-1:0] read_value
);
  kvt_pkg::cmd_t    cmd;
  kvt_pkg::status_t status;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .success     (success),
    .read_value  (read_value)
  );
endmodule

// ----- src/kvt_datapath.sv -----
// Table memories, scan pipeline and result register of the key-value table.
`timescale 1ns / 1ps
module kvt_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kvt_pkg::cmd_t                 cmd,
  output kvt_pkg::status_t              status,
  input  logic [kvt_pkg::FUNC_BITS-1:0] func,
  input  logic [kvt_pkg::DATA_BITS-1:0] lookup_key,
  input  logic [kvt_pkg::DATA_BITS-1:0] store_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          success,
  output logic [kvt_pkg::DATA_BITS-1:0] read_value
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = AW + 1;

  logic [KEY_BITS:0]             kmem [CAPACITY];
  logic [VALUE_BITS-1:0]         vmem [CAPACITY];
  logic [KEY_BITS:0]             kq;
  logic [VALUE_BITS-1:0]         vq;

  logic [kvt_pkg::FUNC_BITS-1:0] req_func;
  logic [KEY_BITS-1:0]           req_key;
  logic [VALUE_BITS-1:0]         req_val;

  logic [CW-1:0]                 idx;
  logic                          p_v;
  logic [AW-1:0]                 p_idx;
  logic                          found;
  logic [AW-1:0]                 found_idx;
  logic                          free_found;
  logic [AW-1:0]                 free_idx;
  logic                          ok;
  logic                          ok_next;
  logic                          at_end;

  logic                          kwe;
  logic [AW-1:0]                 kwa;
  logic [KEY_BITS:0]             kwd;
  logic                          vwe;
  logic [AW-1:0]                 vwa;

  assign at_end = (idx == CW'(CAPACITY));
  assign status.clear_last = (idx == CW'(CAPACITY - 1));
  assign status.scan_done  = at_end && !p_v;
  assign status.out_free   = !out_valid || !out_stall;

  always_comb begin
    kwe = 1'b0;
    kwa = idx[AW-1:0];
    kwd = '0;
    vwe = 1'b0;
    vwa = found_idx;
    ok_next = 1'b0;
    if (cmd.clear_step) begin
      kwe = 1'b1;
    end else if (cmd.act) begin
      case (req_func)
        kvt_pkg::FUNC_GET: begin
          ok_next = found;
        end
        kvt_pkg::FUNC_PUT: begin
          if (found) begin
            vwe = 1'b1;
            ok_next = 1'b1;
          end else if (free_found) begin
            kwe = 1'b1;
            kwa = free_idx;
            kwd = {1'b1, req_key};
            vwe = 1'b1;
            vwa = free_idx;
            ok_next = 1'b1;
          end
        end
        kvt_pkg::FUNC_DEL: begin
          if (found) begin
            kwe = 1'b1;
            kwa = found_idx;
            kwd = {1'b0, req_key};
            ok_next = 1'b1;
          end
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[kwa] <= kwd;
    end
    kq <= kmem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwa] <= req_val;
    end
    vq <= vmem[found_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      p_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.clear_step || (cmd.scan_step && !at_end)) begin
        idx <= idx + CW'(1);
      end
      p_v <= cmd.scan_step && !at_end;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= idx[AW-1:0];
    if (cmd.accept) begin
      req_func   <= func;
      req_key    <= lookup_key[KEY_BITS-1:0];
      req_val    <= store_value[VALUE_BITS-1:0];
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (p_v) begin
      // The first hit and the lowest free entry win.
      if (kq[KEY_BITS] && (kq[KEY_BITS-1:0] == req_key) && !found) begin
        found     <= 1'b1;
        found_idx <= p_idx;
      end
      if (!kq[KEY_BITS] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= p_idx;
      end
    end
    if (cmd.act) begin
      ok <= ok_next;
    end
    if (cmd.load) begin
      success <= ok;
      read_value <= (req_func == kvt_pkg::FUNC_GET && found) ?
                    kvt_pkg::DATA_BITS'(vq) : '0;
    end
  end
endmodule

// ----- src/kvt_ctrl.sv -----
// Sequencing state machine of the key-value table.
`timescale 1ns / 1ps
module kvt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  kvt_pkg::status_t status,
  output kvt_pkg::cmd_t    cmd
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) state_next = S_ACT;
      end
      S_ACT: begin
        cmd.act = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- src/kvt_checker.sv -----
// Port-level checker for the key-value table and its bind.
`timescale 1ns / 1ps
`include "key_value_table_assert.svh"
module kvt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          success,
  input logic [kvt_pkg::DATA_BITS-1:0] read_value
);
  `KVT_CHECK_RST(a_reset_empty, rst |=> !out_valid, "out_valid after reset")
  `KVT_CHECK(a_fail_zero, out_valid && !success |-> read_value == '0, "nonzero value on fail")
  `KVT_CHECK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted twice")
  `KVT_CHECK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
endmodule

bind key_value_table kvt_checker u_kvt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .success    (success),
  .read_value (read_value)
);

// ----- tb/key_value_table_tb.sv -----
// Self-checking testbench for the key-value table: get, put and delete traffic against a predictor.
`timescale 1ns / 1ps
module key_value_table_tb;
  localparam int CAPACITY = 1024;
  localparam logic [kvt_pkg::FUNC_BITS-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int KEY_POOL = 64;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [kvt_pkg::FUNC_BITS-1:0] func;
  logic [kvt_pkg::DATA_BITS-1:0] lookup_key;
  logic [kvt_pkg::DATA_BITS-1:0] store_value;
  logic out_valid;
  logic out_stall;
  logic success;
  logic [kvt_pkg::DATA_BITS-1:0] read_value;

  typedef struct packed {
    logic ok;
    logic [kvt_pkg::DATA_BITS-1:0] value;
  } lookup_result_t;

  // Shadow copy of the table contents.
  logic table_used [CAPACITY];
  logic [kvt_pkg::DATA_BITS-1:0] table_keys [CAPACITY];
  logic [kvt_pkg::DATA_BITS-1:0] table_vals [CAPACITY];
  lookup_result_t pending_results[$];
  logic [kvt_pkg::DATA_BITS-1:0] key_pool [KEY_POOL];

  int send_idle_pct;
  int stall_pct;
  int hold_off_cycles;
  int mismatches;
  int results_seen;
  int idle_cycles;
  int puts_full;
  int gets_hit;

  key_value_table #(
    .CAPACITY(CAPACITY), .KEY_BITS(64), .VALUE_BITS(64)
  ) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .lookup_key(lookup_key), .store_value(store_value), .out_valid(out_valid),
    .out_stall(out_stall), .success(success), .read_value(read_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_slot(logic [kvt_pkg::DATA_BITS-1:0] key);
    for (int i = 0; i < CAPACITY; i++) begin
      if (table_used[i] && table_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic lookup_result_t apply_request(logic [kvt_pkg::FUNC_BITS-1:0] op,
      logic [kvt_pkg::DATA_BITS-1:0] key, logic [kvt_pkg::DATA_BITS-1:0] val);
    lookup_result_t r;
    int slot;
    r = '0;
    slot = find_slot(key);
    case (op)
      kvt_pkg::FUNC_GET: begin
        if (slot >= 0) begin
          r.ok = 1'b1;
          r.value = table_vals[slot];
          gets_hit++;
        end
      end
      kvt_pkg::FUNC_PUT: begin
        if (slot < 0) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (!table_used[i]) begin
              slot = i;
              break;
            end
          end
          if (slot >= 0) begin
            table_used[slot] = 1'b1;
            table_keys[slot] = key;
          end else begin
            puts_full++;
          end
        end
        if (slot >= 0) begin
          table_vals[slot] = val;
          r.ok = 1'b1;
        end
      end
      kvt_pkg::FUNC_DEL: begin
        if (slot >= 0) begin
          table_used[slot] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [kvt_pkg::DATA_BITS-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Sends one request; the expectation is queued when the transaction completes.
  task automatic send_request(logic [kvt_pkg::FUNC_BITS-1:0] op,
      logic [kvt_pkg::DATA_BITS-1:0] key, logic [kvt_pkg::DATA_BITS-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    func <= op;
    lookup_key <= key;
    store_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(op, key, val));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    logic [kvt_pkg::FUNC_BITS-1:0] op;
    logic [kvt_pkg::DATA_BITS-1:0] key;
    pick = $urandom_range(99);
    if (pick < 40) op = kvt_pkg::FUNC_PUT;
    else if (pick < 75) op = kvt_pkg::FUNC_GET;
    else if (pick < 97) op = kvt_pkg::FUNC_DEL;
    else op = FUNC_UNKNOWN;
    key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(KEY_POOL - 1)] : rand_word();
    send_request(op, key, rand_word());
  endtask

  task automatic test_directed_ops();
    send_request(kvt_pkg::FUNC_GET, 64'h0, 64'h0);
    send_request(kvt_pkg::FUNC_DEL, '1, 64'h0);
    send_request(kvt_pkg::FUNC_PUT, 64'h0, '1);
    send_request(kvt_pkg::FUNC_PUT, '1, 64'h0);
    send_request(kvt_pkg::FUNC_GET, 64'h0, 64'h1234);
    send_request(kvt_pkg::FUNC_GET, '1, '1);
    send_request(kvt_pkg::FUNC_PUT, 64'h0, 64'h5555_aaaa_5555_aaaa);
    send_request(kvt_pkg::FUNC_GET, 64'h0, 64'h0);
    send_request(FUNC_UNKNOWN, 64'h0, '1);
    send_request(kvt_pkg::FUNC_DEL, 64'h0, 64'h0);
    send_request(kvt_pkg::FUNC_GET, 64'h0, 64'h0);
    send_request(kvt_pkg::FUNC_DEL, 64'h0, 64'h0);
    send_request(kvt_pkg::FUNC_PUT, 64'haaaa_5555_aaaa_5555, 64'h8000_0000_0000_0001);
    send_request(kvt_pkg::FUNC_GET, 64'haaaa_5555_aaaa_5555, 64'h0);
    send_request(kvt_pkg::FUNC_DEL, '1, 64'h0);
    send_request(kvt_pkg::FUNC_DEL, 64'haaaa_5555_aaaa_5555, 64'h0);
    drain();
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) send_random_request();
    drain();
  endtask

  // Fills the table to the brim, forces a full-table put, then frees one entry for a retry.
  task automatic test_full_table();
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < KEY_POOL; i++) send_request(kvt_pkg::FUNC_DEL, key_pool[i], 64'h0);
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(kvt_pkg::FUNC_PUT, 64'h1000 + i, rand_word());
    end
    send_request(kvt_pkg::FUNC_PUT, 64'hdead_beef, 64'h1);
    send_request(kvt_pkg::FUNC_GET, 64'h1000 + CAPACITY - 1, 64'h0);
    send_request(kvt_pkg::FUNC_DEL, 64'h1000 + 7, 64'h0);
    send_request(kvt_pkg::FUNC_PUT, 64'hdead_beef, 64'h2);
    send_request(kvt_pkg::FUNC_GET, 64'hdead_beef, 64'h0);
    drain();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 3 * (CAPACITY + 8);
    for (int i = 0; i < 6; i++) send_random_request();
    drain();
  endtask

  // Result checker and receiver stall generator.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: success=%0b read_value=%h",
              success, read_value);
        end else begin
          want = pending_results.pop_front();
          if (success !== want.ok || read_value !== want.value) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %0b/%h, got %0b/%h",
                want.ok, want.value, success, read_value);
          end
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("key_value_table_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    lookup_key = '0;
    store_value = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    puts_full = 0;
    gets_hit = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      table_used[i] = 1'b0;
      table_keys[i] = '0;
      table_vals[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = (i < 4) ? i : rand_word();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    send_idle_pct = 0;  stall_pct = 0;  test_random_traffic(95);
    send_idle_pct = 47; stall_pct = 0;  test_random_traffic(95);
    send_idle_pct = 0;  stall_pct = 47; test_random_traffic(95);
    send_idle_pct = 20; stall_pct = 20; test_random_traffic(95);
    test_back_pressure();
    test_full_table();
    repeat (CAPACITY + 20) @(posedge clk);

    $display("Covered get, put, delete and unknown operations, %0d results checked,",
        results_seen);
    $display("%0d get hits, %0d full-table puts, under idle and stall phases.",
        gets_hit, puts_full);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("key_value_table_tb: clean");
    end else begin
      $display("key_value_table_tb: errors");
    end
    $finish;
  end
endmodule
